// ----- design/acss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan sequencer package
// Shared types, opcodes and default constants for the converter scan sequencer.
// ----------------------------------------------------------------------------
package acss_pkg;

    localparam int CHANNELS_DEFAULT = 8;
    localparam int MASK_W   = 8;
    localparam int SAMPLE_W = 10;
    localparam int CHAN_W   = 3;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DONE  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [MASK_W-1:0]   channel_mask;
        logic [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]   read_channel;
    } scan_item_t;

    typedef struct packed {
        logic                accepted;
        logic                busy_res;
        logic [CHAN_W-1:0]   mux_channel;
        logic                start_conversion;
        logic [SAMPLE_W-1:0] read_value;
        logic                read_was_valid;
        logic [MASK_W-1:0]   valid_bits;
    } scan_result_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } acss_state_t;

endpackage

// ----- design/acss_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan sequencer controller
// Two-state machine that captures a transaction, runs it through the datapath
// and raises the result strobe in the following cycle.
// ----------------------------------------------------------------------------
module acss_ctrl
    import acss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    output dp_cmd_t cmd,
    output logic    result_valid
);

    acss_state_t state_reg;
    acss_state_t state_next;
    logic        result_valid_reg;
    logic        result_valid_next;

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                state_next = start ? ST_EXEC : ST_IDLE;
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
                cmd.execute = 1'b0;
            end
            ST_EXEC:
            begin
                busy        = 1'b1;
                cmd.capture = 1'b0;
                cmd.execute = 1'b1;
            end
            default:
            begin
                busy        = 1'b1;
                cmd.capture = 1'b0;
                cmd.execute = 1'b0;
            end
        endcase
        result_valid_next = cmd.execute;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

    // Every execute cycle is followed by exactly one strobe.
    a_strobe_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_EXEC))
        else $error("result strobe without a preceding execute cycle");

    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |=> state_reg == ST_IDLE && result_valid)
        else $error("execute did not complete in one cycle");

    a_capture_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !busy && start)
        else $error("capture issued while busy");

endmodule

// ----- design/acss_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan sequencer datapath
// Holds the scan state, per-channel sample store and fresh mask, and
// produces one registered result for each executed transaction.
// ----------------------------------------------------------------------------
module acss_datapath
    import acss_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  dp_cmd_t      cmd,
    input  scan_item_t   item,
    output scan_result_t result
);

    scan_item_t          item_reg;
    logic                busy_reg;
    logic                busy_next;
    logic [MASK_W-1:0]   rem_reg;
    logic [MASK_W-1:0]   rem_next;
    logic [CHAN_W-1:0]   cur_reg;
    logic [CHAN_W-1:0]   cur_next;
    logic [MASK_W-1:0]   fresh_reg;
    logic [MASK_W-1:0]   fresh_next;
    logic [SAMPLE_W-1:0] store_reg [CHANNELS];
    logic [SAMPLE_W-1:0] store_next [CHANNELS];
    scan_result_t        res_reg;
    scan_result_t        res_next;

    logic [MASK_W-1:0]   ch_mask;
    logic [MASK_W-1:0]   start_mask;
    logic [MASK_W-1:0]   done_rem;
    logic [MASK_W-1:0]   search_mask;
    logic [CHAN_W-1:0]   low_ch;
    logic                acc;
    logic                go;
    logic [SAMPLE_W-1:0] rval;
    logic                rvalid;

    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            ch_mask[i] = (i < CHANNELS);
        end
    end

    assign start_mask = item_reg.channel_mask & ch_mask;
    assign done_rem   = rem_reg & ~(MASK_W'(1) << cur_reg) & ch_mask;

    // One priority encoder serves both the start and the advance after done.
    assign search_mask = (item_reg.opcode == OP_START) ? start_mask : done_rem;

    always_comb
    begin
        low_ch = '0;
        for (int i = CHANNELS - 1; i >= 0; i--)
        begin
            if (search_mask[i])
            begin
                low_ch = CHAN_W'(i);
            end
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        rem_next   = rem_reg;
        cur_next   = cur_reg;
        fresh_next = fresh_reg;
        store_next = store_reg;
        acc        = 1'b0;
        go         = 1'b0;
        rval       = '0;
        rvalid     = 1'b0;

        case (item_reg.opcode)
            OP_START:
            begin
                if (!busy_reg && start_mask != '0)
                begin
                    rem_next   = start_mask;
                    cur_next   = low_ch;
                    fresh_next = '0;
                    busy_next  = 1'b1;
                    acc        = 1'b1;
                    go         = 1'b1;
                end
            end
            OP_DONE:
            begin
                if (busy_reg)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (cur_reg == CHAN_W'(i))
                        begin
                            store_next[i] = item_reg.sample;
                            fresh_next[i] = 1'b1;
                        end
                    end
                    rem_next = done_rem;
                    if (done_rem == '0)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        cur_next = low_ch;
                        go       = 1'b1;
                    end
                end
            end
            OP_READ:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (item_reg.read_channel == CHAN_W'(i))
                    begin
                        rval          = store_reg[i];
                        rvalid        = fresh_reg[i];
                        fresh_next[i] = 1'b0;
                    end
                end
            end
            default:
            begin
                // Unused opcode: status is reported, nothing changes.
            end
        endcase

        res_next.accepted         = acc;
        res_next.busy_res         = busy_next;
        res_next.mux_channel      = cur_next;
        res_next.start_conversion = go;
        res_next.read_value       = rval;
        res_next.read_was_valid   = rvalid;
        res_next.valid_bits       = fresh_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.execute)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            rem_reg   <= '0;
            cur_reg   <= '0;
            fresh_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (cmd.execute)
        begin
            busy_reg  <= busy_next;
            rem_reg   <= rem_next;
            cur_reg   <= cur_next;
            fresh_reg <= fresh_next;
            store_reg <= store_next;
        end
    end

    assign result = res_reg;

    // The scan is running exactly while channels remain to be converted.
    a_busy_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (rem_reg != '0))
        else $error("busy flag disagrees with remaining mask");

    a_fresh_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fresh_reg & ~ch_mask) == '0 && (rem_reg & ~ch_mask) == '0)
        else $error("mask bit set above the channel count");

    a_current_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg[cur_reg])
        else $error("selected channel is not in the remaining mask");

endmodule

// ----- design/adc_channel_scan_sequencer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Converter channel scan sequencer
// Sequences conversions over a channel mask, stores one sample per channel
// and returns stored samples with their fresh flags on request.
//
//   Channel   Handshake             Payload
//   input     start / busy          item   (scan_item_t)
//   result    result_valid strobe   result (scan_result_t)
//
// A transaction is accepted on a clock edge with start high and busy low.
// busy is high for the one execute cycle that follows; the result strobe is
// high in the cycle after that, and a new transaction can be accepted while
// the previous result is shown. The rate is set by the capture-then-execute
// sequence of the controller. Reset clears the scan state, fresh mask and the
// whole sample store at once. The receiver cannot stall, so the result is
// valid for exactly one cycle.
// ----------------------------------------------------------------------------
module adc_channel_scan_sequencer_top
    import acss_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  scan_item_t   item,
    output logic         result_valid,
    output scan_result_t result
);

    dp_cmd_t cmd;

    acss_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid)
    );

    acss_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .result (result)
    );

endmodule
